@@ hdl/mlfq_pkg.sv @@
package mlfq_pkg;

  localparam int NumLevels  = 10;
  localparam int NumClasses = 4;
  localparam int QueueDepth = 16;
  localparam int NumQueues  = NumLevels * NumClasses;

  localparam int LvlW   = 4;
  localparam int ClsW   = 2;
  localparam int QW     = $clog2(NumQueues);
  localparam int PtrW   = $clog2(QueueDepth);
  localparam int CntW   = $clog2(QueueDepth + 1);
  localparam int AddrW  = QW + PtrW;
  localparam int EntryW = 40;
  localparam int SliceW = 10;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SELECT = 1'b1;

  // classified command passed from front end to back end
  typedef struct packed {
    logic              op;
    logic              ready;
    logic [7:0]        id;
    logic [LvlW-1:0]   lvl;
    logic [QW-1:0]     q;
    logic [15:0]       svc;
    logic [15:0]       burst;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);

  typedef struct packed {
    logic        found;
    logic        queue_full;
    logic [7:0]  chosen_id;
    logic [3:0]  chosen_level;
    logic [9:0]  slice_ticks;
    logic [15:0] runtime;
    logic [15:0] new_service_time;
    logic [3:0]  stored_level;
  } res_t;

endpackage

@@ hdl/mlfq_front.sv @@
module mlfq_front import mlfq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [47:0] in_data,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  // two-entry queue of classified commands
  cmd_t       fifo [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  cmd_t       c_new;
  logic [3:0] lvl_in;
  logic [1:0] cls_in;
  logic [15:0] svc_in;
  logic       demote;

  always_comb begin
    lvl_in = in_data[14:11];
    cls_in = in_data[10:9];
    svc_in = in_data[30:15];
    if (lvl_in > LvlW'(NumLevels - 1)) lvl_in = LvlW'(NumLevels - 1);
    if (32'(cls_in) > NumClasses - 1) cls_in = ClsW'(NumClasses - 1);
    demote = (32'(svc_in) >= (32'd1 << lvl_in));
    c_new.op    = in_data[0];
    c_new.id    = in_data[8:1];
    c_new.burst = in_data[46:31];
    c_new.ready = in_data[47];
    c_new.svc   = demote ? 16'd0 : svc_in;
    c_new.lvl   = (demote && lvl_in < LvlW'(NumLevels - 1)) ? lvl_in + 4'd1 : lvl_in;
    c_new.q     = QW'(32'(c_new.lvl) * NumClasses + 32'(cls_in));
  end

  assign in_ready  = (count != 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready) begin
        fifo[wr_ptr] <= c_new;
        wr_ptr <= ~wr_ptr;
      end
      if (cmd_valid && cmd_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready) - 2'(cmd_valid && cmd_ready);
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count overflow");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    count == 2'd2 |-> !in_ready) else $error("accepted while full");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    count == 2'd0 |-> !cmd_valid) else $error("issued from empty queue");

endmodule

@@ hdl/mlfq_back.sv @@
module mlfq_back import mlfq_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cmd_valid,
  output logic  cmd_ready,
  input  cmd_t  cmd,
  output logic  res_valid,
  input  logic  res_ready,
  output res_t  res
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_DONE} state_t;
  state_t state;

  logic [EntryW-1:0] mem [NumQueues*QueueDepth];
  logic [EntryW-1:0] rd_data;

  logic [PtrW-1:0] head [NumQueues];
  logic [PtrW-1:0] tail [NumQueues];
  logic [CntW-1:0] fill [NumQueues];

  // per-queue non-empty flags and priority pick of the lowest queue number
  logic [NumQueues-1:0] nonempty;
  logic                 any;
  logic [QW-1:0]        pick;
  logic [QW-1:0]        sel_q;
  logic [16:0]          sum;
  logic [LvlW-1:0]      sel_lvl;
  logic                 has_room;
  res_t                 add_res;
  res_t                 done_res;

  always_comb begin
    any  = 1'b0;
    pick = '0;
    for (int i = NumQueues - 1; i >= 0; i--) begin
      nonempty[i] = (fill[i] != '0);
      if (nonempty[i]) begin
        any  = 1'b1;
        pick = QW'(i);
      end
    end
  end

  assign sum       = {1'b0, rd_data[31:16]} + {1'b0, rd_data[15:0]};
  assign sel_lvl   = LvlW'(32'(sel_q) / NumClasses);
  assign cmd_ready = (state == S_IDLE) && (!res_valid || res_ready);
  assign has_room  = (32'(fill[cmd.q]) < QueueDepth);

  // add result: stored level shown even when the queue is full
  always_comb begin
    add_res = '0;
    if (cmd.ready) begin
      add_res.stored_level = cmd.lvl;
      if (has_room) add_res.found = 1'b1;
      else add_res.queue_full = 1'b1;
    end
  end

  // select result from the head entry read out of memory
  always_comb begin
    done_res                  = '0;
    done_res.found            = 1'b1;
    done_res.chosen_id        = rd_data[39:32];
    done_res.chosen_level     = sel_lvl;
    done_res.slice_ticks      = (sel_lvl >= 4'd10) ? 10'd1023 : (10'd1 << sel_lvl);
    done_res.runtime          = rd_data[31:16];
    done_res.new_service_time = sum[16] ? 16'hFFFF : sum[15:0];
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready && cmd.op == OP_ADD && cmd.ready && has_room)
      mem[{cmd.q, tail[cmd.q]}] <= {cmd.id, cmd.svc, cmd.burst};
    rd_data <= mem[{pick, head[pick]}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      sel_q     <= '0;
      for (int i = 0; i < NumQueues; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd_ready) begin
            if (cmd.op == OP_ADD) begin
              res       <= add_res;
              res_valid <= 1'b1;
              if (cmd.ready && has_room) begin
                tail[cmd.q] <= PtrW'(32'(tail[cmd.q]) + 1 == QueueDepth ? 0
                               : 32'(tail[cmd.q]) + 1);
                fill[cmd.q] <= fill[cmd.q] + CntW'(1);
              end
            end else if (any) begin
              sel_q     <= pick;
              res_valid <= 1'b0;
              state     <= S_READ;
            end else begin
              res       <= '0;
              res_valid <= 1'b1;
            end
          end else if (res_ready) begin
            res_valid <= 1'b0;
          end
        end
        S_READ: state <= S_DONE;
        S_DONE: begin
          res         <= done_res;
          head[sel_q] <= PtrW'(32'(head[sel_q]) + 1 == QueueDepth ? 0
                         : 32'(head[sel_q]) + 1);
          fill[sel_q] <= fill[sel_q] - CntW'(1);
          res_valid   <= 1'b1;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !cmd_ready) else $error("command taken while busy");
  a_seq: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |=> state == S_DONE) else $error("select sequence broken");
  a_sel: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> nonempty[sel_q]) else $error("selected empty queue");

endmodule

@@ hdl/mlfq_thread_scheduler.sv @@
// Multilevel feedback queue scheduler: ten levels of four FIFO classes, 16
// entries each. An add transfer demotes and enqueues a thread, a select
// transfer dequeues the head of the lowest non-empty level/class. The front
// end classifies items into a two-entry queue; the back end owns the pointer
// state and a 640 x 40 entry memory. An add is handled in the issue state;
// a select steps through issue, registered memory read and result, and the
// back end takes no new command meanwhile. The two-entry front queue keeps
// taking transfers while a result waits, until full. No reset clearing pass is needed.
module mlfq_thread_scheduler import mlfq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op
  input  logic        s_tuser,
  // thread_id, prio_class, level, service_time, burst_length, is_ready
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // found, queue_full, chosen_id, chosen_level, slice_ticks, runtime,
  // new_service_time, stored_level
  output logic [63:0] m_tdata
);

  cmd_t cmd;
  logic cmd_valid, cmd_ready;
  res_t res;

  mlfq_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_data({s_tdata[46:0], s_tuser}),
    .cmd_valid, .cmd_ready, .cmd
  );

  mlfq_back u_back (
    .clk, .rst,
    .cmd_valid, .cmd_ready, .cmd,
    .res_valid(m_tvalid), .res_ready(m_tready), .res
  );

  assign m_tdata = {4'd0, res.stored_level, res.new_service_time, res.runtime,
                    res.slice_ticks, res.chosen_level, res.chosen_id,
                    res.queue_full, res.found};

endmodule
